// ===== rtl/core/scl_pkg.sv =====
// shared types, constants and helper functions for the sparse column localizer
package scl_pkg;

    localparam int MAX_COLUMNS = 65536;
    localparam int MAX_PROCS   = 64;

    localparam int COL_W   = $clog2(MAX_COLUMNS);
    localparam int IDX_W   = 17;
    localparam int RANK_W  = 6;
    localparam int NP_W    = 7;
    localparam int BASE_W  = 17;
    localparam int ROW_W   = 24;
    localparam int EPOCH_W = 8;
    localparam int CNT_AW  = $clog2(MAX_PROCS);
    localparam int CFG_IW  = 2;

    localparam logic KIND_LOCALIZE = 1'b0;
    localparam logic KIND_RESTART  = 1'b1;

    localparam logic [CFG_IW-1:0] REG_MY_RANK    = 2'd0;
    localparam logic [CFG_IW-1:0] REG_NUM_PROCS  = 2'd1;
    localparam logic [CFG_IW-1:0] REG_BASE_ROWS  = 2'd2;
    localparam logic [CFG_IW-1:0] REG_EXTRA_ROWS = 2'd3;

    typedef struct packed {
        logic              kind;
        logic [COL_W-1:0]  global_column;
    } t_in;

    typedef struct packed {
        logic [COL_W-1:0]  local_column;
        logic [RANK_W-1:0] owner_id;
        logic              is_ghost;
        logic              new_ghost;
        logic [15:0]       list_position;
        logic              out_of_range;
    } t_out;

    typedef struct packed {
        logic [RANK_W-1:0] my_rank;
        logic [NP_W-1:0]   proc_count;
        logic [BASE_W-1:0] rows_each;
        logic [RANK_W-1:0] spare_rows;
    } t_cfg;

    // outcome of the owner search
    typedef struct packed {
        logic              found;
        logic [RANK_W-1:0] owner;
        logic [COL_W-1:0]  local_column;
    } t_own;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [IDX_W-1:0]   index;
    } t_ghost_entry;

    function automatic logic [NP_W-1:0] eff_procs(input logic [NP_W-1:0] np);
        logic [NP_W-1:0] r;
        r = np;
        if (np == '0) begin
            r = NP_W'(1);
        end else if (np > NP_W'(MAX_PROCS)) begin
            r = NP_W'(MAX_PROCS);
        end
        return r;
    endfunction

    function automatic logic [RANK_W-1:0] min_rank(input logic [RANK_W-1:0] a,
                                                   input logic [RANK_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [IDX_W-1:0] own_rows(input t_cfg c);
        logic [IDX_W-1:0] r;
        r = '0;
        if (NP_W'(c.my_rank) < eff_procs(c.proc_count)) begin
            r = IDX_W'(c.rows_each) + IDX_W'(c.my_rank < c.spare_rows);
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/scl_owner_search.sv =====
// owner search: bit-serial binary search over block starts, one rank bit per cycle
module scl_owner_search (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [scl_pkg::COL_W-1:0]  i_col,
    input  scl_pkg::t_cfg              i_cfg,
    output logic                       o_done,
    output scl_pkg::t_own              o_res
);

    logic                        r_run;
    logic                        r_fin;
    logic                        r_done;
    logic [scl_pkg::RANK_W-1:0]  r_mask;
    logic [scl_pkg::ROW_W-1:0]   r_add;
    logic [scl_pkg::RANK_W-1:0]  r_p;
    logic [scl_pkg::ROW_W-1:0]   r_prod;
    logic [scl_pkg::COL_W-1:0]   r_col;
    scl_pkg::t_own               r_res;

    logic [scl_pkg::NP_W-1:0]    np_eff;
    logic [scl_pkg::RANK_W-1:0]  cand;
    logic [scl_pkg::ROW_W-1:0]   cand_prod;
    logic [scl_pkg::ROW_W-1:0]   cand_start;
    logic                        take;
    logic [scl_pkg::ROW_W-1:0]   blk_start;
    logic [scl_pkg::ROW_W-1:0]   blk_end;
    scl_pkg::t_own               n_res;

    assign np_eff     = scl_pkg::eff_procs(i_cfg.proc_count);
    assign cand       = r_p | r_mask;
    // running product p*base grows by base shifted to the tried bit
    assign cand_prod  = r_prod + r_add;
    assign cand_start = cand_prod
                      + scl_pkg::ROW_W'(scl_pkg::min_rank(cand, i_cfg.spare_rows));
    assign take       = (scl_pkg::NP_W'(cand) < np_eff)
                      && (cand_start <= scl_pkg::ROW_W'(r_col));

    assign blk_start = r_prod + scl_pkg::ROW_W'(scl_pkg::min_rank(r_p, i_cfg.spare_rows));
    assign blk_end   = blk_start + scl_pkg::ROW_W'(i_cfg.rows_each)
                     + scl_pkg::ROW_W'(r_p < i_cfg.spare_rows);

    always_comb begin
        n_res.found        = scl_pkg::ROW_W'(r_col) < blk_end;
        n_res.owner        = r_p;
        n_res.local_column = r_col - blk_start[scl_pkg::COL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && r_mask[0]) begin
                r_run <= 1'b0;
                r_fin <= 1'b1;
            end
            if (r_fin) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_col  <= i_col;
            r_p    <= '0;
            r_prod <= '0;
            r_mask <= scl_pkg::RANK_W'(1) << (scl_pkg::RANK_W - 1);
            r_add  <= scl_pkg::ROW_W'(i_cfg.rows_each) << (scl_pkg::RANK_W - 1);
        end else if (r_run) begin
            if (take) begin
                r_p    <= cand;
                r_prod <= cand_prod;
            end
            r_mask <= r_mask >> 1;
            r_add  <= r_add >> 1;
        end
        if (r_fin) begin
            r_res <= n_res;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ===== rtl/core/scl_rx_count.sv =====
// per-owner receive counters in a synchronous memory, valid bits give the zero reset
module scl_rx_count (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_clear,
    input  logic                        i_rd_en,
    input  logic [scl_pkg::CNT_AW-1:0]  i_rd_addr,
    output logic [scl_pkg::IDX_W-1:0]   o_rd_data,
    input  logic                        i_wr_en,
    input  logic [scl_pkg::CNT_AW-1:0]  i_wr_addr,
    input  logic [scl_pkg::IDX_W-1:0]   i_wr_data
);

    logic [scl_pkg::IDX_W-1:0]     r_mem [scl_pkg::MAX_PROCS];
    logic [scl_pkg::MAX_PROCS-1:0] r_valid;
    logic [scl_pkg::IDX_W-1:0]     r_rd_data;
    logic                          r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_clear) begin
                r_valid <= '0;
            end else if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    // a counter never written since restart reads as zero
    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

// ===== rtl/core/sparse_column_localizer_unit.sv =====
// Sparse column localizer: maps global column indices to local/ghost indices.
// One item is taken at a time. A localize item first goes through the owner search,
// which resolves one rank bit per cycle and then registers its result. A local or
// out-of-range column is answered from S_SEARCH once the owner is handed over; for a
// remote column the ghost map and the receive counters are read there, then updated
// and written back in S_UPDATE, which puts out the result strobe.
// busy falls in the cycle that carries the result strobe, so the next item can
// follow right away. A restart item answers in the cycle after it is taken. The
// ghost map is tagged with an epoch that a restart or register write advances;
// after reset, and once every 255 restarts when the epoch runs out, a clearing
// pass sweeps all 65536 entries of the map while busy stays high. Results cannot
// be held off: each one is valid for exactly the cycle its strobe is high.
// Configuration writes are always taken and restart the block.
module sparse_column_localizer_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  scl_pkg::t_in                i_item,
    output logic                        o_result_strobe,
    output scl_pkg::t_out               o_result,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [scl_pkg::CFG_IW-1:0]  i_cfg_index,
    input  logic [scl_pkg::IDX_W-1:0]   i_cfg_data
);

    typedef enum logic [3:0] {
        S_CLEAR  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_SEARCH = 4'b0100,
        S_UPDATE = 4'b1000
    } t_state;

    t_state                         r_state, n_state;
    logic [scl_pkg::EPOCH_W-1:0]    r_epoch, n_epoch;
    logic [scl_pkg::COL_W-1:0]      r_clr_addr, n_clr_addr;
    logic [scl_pkg::IDX_W-1:0]      r_next_ghost, n_next_ghost;
    scl_pkg::t_cfg                  r_cfg, n_cfg;
    scl_pkg::t_out                  r_out, n_out;
    logic                           r_stb, n_stb;
    logic [scl_pkg::COL_W-1:0]      r_col, n_col;
    logic [scl_pkg::RANK_W-1:0]     r_owner, n_owner;

    scl_pkg::t_ghost_entry          r_ghost_mem [scl_pkg::MAX_COLUMNS];
    scl_pkg::t_ghost_entry          r_gm_rd;
    logic                           gm_we;
    logic                           gm_re;
    logic [scl_pkg::COL_W-1:0]      gm_waddr;
    scl_pkg::t_ghost_entry          gm_wdata;

    logic                           srch_start;
    logic                           srch_done;
    scl_pkg::t_own                  srch_res;

    logic                           cnt_clear;
    logic                           cnt_re;
    logic                           cnt_we;
    logic [scl_pkg::IDX_W-1:0]      cnt_rd;
    logic [scl_pkg::IDX_W-1:0]      cnt_wdata;

    logic                           accept;
    logic                           restart;
    logic                           hit;

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign hit         = (r_gm_rd.epoch == r_epoch);

    scl_owner_search u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (srch_start),
        .i_col   (i_item.global_column),
        .i_cfg   (r_cfg),
        .o_done  (srch_done),
        .o_res   (srch_res)
    );

    scl_rx_count u_rx_count (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (cnt_clear),
        .i_rd_en   (cnt_re),
        .i_rd_addr (srch_res.owner),
        .o_rd_data (cnt_rd),
        .i_wr_en   (cnt_we),
        .i_wr_addr (r_owner),
        .i_wr_data (cnt_wdata)
    );

    always_comb begin
        n_state      = r_state;
        n_epoch      = r_epoch;
        n_clr_addr   = r_clr_addr;
        n_next_ghost = r_next_ghost;
        n_cfg        = r_cfg;
        n_out        = r_out;
        n_stb        = 1'b0;
        n_col        = r_col;
        n_owner      = r_owner;
        gm_we        = 1'b0;
        gm_re        = 1'b0;
        gm_waddr     = r_col;
        gm_wdata     = '0;
        srch_start   = 1'b0;
        cnt_re       = 1'b0;
        cnt_we       = 1'b0;
        cnt_wdata    = cnt_rd + scl_pkg::IDX_W'(1);
        restart      = 1'b0;

        if (i_cfg_valid) begin
            restart = 1'b1;
            case (i_cfg_index)
                scl_pkg::REG_MY_RANK:    n_cfg.my_rank    = i_cfg_data[scl_pkg::RANK_W-1:0];
                scl_pkg::REG_NUM_PROCS:  n_cfg.proc_count = i_cfg_data[scl_pkg::NP_W-1:0];
                scl_pkg::REG_BASE_ROWS:  n_cfg.rows_each  = i_cfg_data[scl_pkg::BASE_W-1:0];
                scl_pkg::REG_EXTRA_ROWS: n_cfg.spare_rows = i_cfg_data[scl_pkg::RANK_W-1:0];
                default:                 restart = 1'b0;
            endcase
        end

        case (r_state)
            S_CLEAR: begin
                gm_we      = 1'b1;
                gm_waddr   = r_clr_addr;
                n_clr_addr = r_clr_addr + scl_pkg::COL_W'(1);
                if (&r_clr_addr) begin
                    n_state = S_IDLE;
                    n_epoch = scl_pkg::EPOCH_W'(1);
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_item.kind == scl_pkg::KIND_RESTART) begin
                        restart = 1'b1;
                        n_out   = '0;
                        n_stb   = 1'b1;
                    end else begin
                        n_col      = i_item.global_column;
                        srch_start = 1'b1;
                        n_state    = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (srch_done) begin
                    n_owner = srch_res.owner;
                    n_out   = '0;
                    if (!srch_res.found) begin
                        n_out.out_of_range = 1'b1;
                        n_stb              = 1'b1;
                        n_state            = S_IDLE;
                    end else if (srch_res.owner == r_cfg.my_rank) begin
                        n_out.owner_id     = srch_res.owner;
                        n_out.local_column = srch_res.local_column;
                        n_stb              = 1'b1;
                        n_state            = S_IDLE;
                    end else begin
                        gm_re   = 1'b1;
                        cnt_re  = 1'b1;
                        n_state = S_UPDATE;
                    end
                end
            end
            S_UPDATE: begin
                n_out          = '0;
                n_out.owner_id = r_owner;
                n_out.is_ghost = 1'b1;
                if (hit) begin
                    n_out.local_column = r_gm_rd.index[scl_pkg::COL_W-1:0];
                end else begin
                    // first sight of this remote column: allocate a ghost index
                    gm_we               = 1'b1;
                    gm_wdata.epoch      = r_epoch;
                    gm_wdata.index      = r_next_ghost;
                    cnt_we              = 1'b1;
                    n_next_ghost        = r_next_ghost + scl_pkg::IDX_W'(1);
                    n_out.local_column  = r_next_ghost[scl_pkg::COL_W-1:0];
                    n_out.new_ghost     = 1'b1;
                    n_out.list_position = cnt_rd[15:0];
                end
                n_stb   = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // restart: new epoch invalidates the ghost map, a sweep when it runs out
        if (restart) begin
            n_next_ghost = scl_pkg::own_rows(n_cfg);
            if (r_state != S_CLEAR) begin
                if (&r_epoch) begin
                    n_state    = S_CLEAR;
                    n_clr_addr = '0;
                end else begin
                    n_epoch = r_epoch + scl_pkg::EPOCH_W'(1);
                end
            end
        end
    end

    assign cnt_clear = restart;

    always_ff @(posedge i_clk) begin
        if (gm_we) begin
            r_ghost_mem[gm_waddr] <= gm_wdata;
        end
        if (gm_re) begin
            r_gm_rd <= r_ghost_mem[r_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_epoch      <= scl_pkg::EPOCH_W'(1);
            r_clr_addr   <= '0;
            r_next_ghost <= '0;
            r_cfg        <= '{my_rank: '0, proc_count: scl_pkg::NP_W'(1),
                              rows_each: '0, spare_rows: '0};
            r_stb        <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_epoch      <= n_epoch;
            r_clr_addr   <= n_clr_addr;
            r_next_ghost <= n_next_ghost;
            r_cfg        <= n_cfg;
            r_stb        <= n_stb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out   <= n_out;
        r_col   <= n_col;
        r_owner <= n_owner;
    end

    assign o_result_strobe = r_stb;
    assign o_result        = r_out;

endmodule

// ===== sim/tb.sv =====
// self-checking testbench for the sparse column localizer with a ghost renumbering scoreboard
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 200000;
    localparam int SHOW_LIMIT  = 40;
    localparam int PHASE_ITEMS = 80;
    localparam int TAIL_CYCLES = 24;

    localparam logic [scl_pkg::CFG_IW-1:0] REG_ORDER [4] = '{
        scl_pkg::REG_MY_RANK, scl_pkg::REG_NUM_PROCS,
        scl_pkg::REG_BASE_ROWS, scl_pkg::REG_EXTRA_ROWS};

    // rank, process count, base rows, extra rows
    localparam int FIXED_LAYOUTS [8][4] = '{
        '{5, 4, 7, 1},          // rank beyond the processes, no own rows
        '{1, 3, 5, 10},         // more extra rows than processes
        '{0, 0, 20, 1},         // zero process count acts as one
        '{3, 100, 50, 63},      // process count clipped to the maximum
        '{1, 2, 131070, 5},     // ghost numbering starts at the top and wraps
        '{63, 64, 1024, 0},     // blocks cover every column exactly
        '{0, 64, 0, 63},        // only the extra rows exist
        '{7, 127, 65536, 0}     // ghost indices above 16 bits
    };

    // expected renumbering of each accepted column, compared with the block's results
    class ghost_numbering;
        logic [scl_pkg::RANK_W-1:0] rank;
        logic [scl_pkg::NP_W-1:0]   procs;
        logic [scl_pkg::BASE_W-1:0] base;
        logic [scl_pkg::RANK_W-1:0] extra;
        logic [scl_pkg::IDX_W-1:0]  ghost_of [int];
        logic [scl_pkg::IDX_W-1:0]  next_ghost;
        logic [scl_pkg::IDX_W-1:0]  recv_cnt [scl_pkg::MAX_PROCS];
        scl_pkg::t_out              renumbers_due [$];
        int                         errors;
        int                         shown;
        int                         n_local, n_new, n_seen, n_oor, n_restart;

        function new();
            rank = '0;
            procs = scl_pkg::NP_W'(1);
            base = '0;
            extra = '0;
            errors = 0;
            shown = 0;
            n_local = 0;
            n_new = 0;
            n_seen = 0;
            n_oor = 0;
            n_restart = 0;
            clear_map();
        endfunction

        function int procs_in_use();
            if (procs == '0) return 1;
            if (procs > scl_pkg::NP_W'(scl_pkg::MAX_PROCS)) return scl_pkg::MAX_PROCS;
            return int'(procs);
        endfunction

        function longint rows_of(int p);
            return longint'(base) + ((p < int'(extra)) ? 1 : 0);
        endfunction

        function longint first_row(int p);
            return longint'(p) * longint'(base) + ((p < int'(extra)) ? p : int'(extra));
        endfunction

        // number of columns that some block holds
        function int span();
            longint t;
            t = first_row(procs_in_use());
            return (t > 65536) ? 65536 : int'(t);
        endfunction

        function void clear_map();
            ghost_of.delete();
            foreach (recv_cnt[p]) recv_cnt[p] = '0;
            if (int'(rank) >= procs_in_use()) next_ghost = '0;
            else next_ghost = scl_pkg::IDX_W'(rows_of(int'(rank)));
        endfunction

        function void set_reg(logic [scl_pkg::CFG_IW-1:0] idx,
                              logic [scl_pkg::IDX_W-1:0] val);
            case (idx)
                scl_pkg::REG_MY_RANK:    rank  = val[scl_pkg::RANK_W-1:0];
                scl_pkg::REG_NUM_PROCS:  procs = val[scl_pkg::NP_W-1:0];
                scl_pkg::REG_BASE_ROWS:  base  = val[scl_pkg::BASE_W-1:0];
                scl_pkg::REG_EXTRA_ROWS: extra = val[scl_pkg::RANK_W-1:0];
                default: ;
            endcase
            clear_map();
        endfunction

        function void take_item(scl_pkg::t_in it);
            scl_pkg::t_out r;
            int            owner;
            int            col;
            longint        lo;
            r = '0;
            owner = -1;
            col = int'(it.global_column);
            if (it.kind == scl_pkg::KIND_RESTART) begin
                clear_map();
                n_restart++;
                renumbers_due.push_back(r);
                return;
            end
            for (int p = 0; p < procs_in_use(); p++) begin
                lo = first_row(p);
                if (col >= lo && col < lo + rows_of(p)) begin
                    owner = p;
                    break;
                end
            end
            if (owner < 0) begin
                r.out_of_range = 1'b1;
                n_oor++;
            end else begin
                r.owner_id = scl_pkg::RANK_W'(owner);
                if (owner == int'(rank)) begin
                    r.local_column = scl_pkg::COL_W'(col - first_row(owner));
                    n_local++;
                end else begin
                    r.is_ghost = 1'b1;
                    if (!ghost_of.exists(col)) begin
                        ghost_of[col] = next_ghost;
                        next_ghost = next_ghost + 1'b1;  // wraps within 17 bits
                        r.new_ghost = 1'b1;
                        r.list_position = recv_cnt[owner][15:0];
                        recv_cnt[owner] = recv_cnt[owner] + 1'b1;
                        n_new++;
                    end else begin
                        n_seen++;
                    end
                    r.local_column = scl_pkg::COL_W'(ghost_of[col]);
                end
            end
            renumbers_due.push_back(r);
        endfunction

        function bit same(string fname, int unsigned want, int unsigned got);
            if (want != got && shown < SHOW_LIMIT)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
            return want == got;
        endfunction

        function void match_result(scl_pkg::t_out got);
            scl_pkg::t_out want;
            bit            ok;
            if (renumbers_due.size() == 0) begin
                if (shown < SHOW_LIMIT)
                    $display("%0t: result with nothing expected, expected none, actual %h",
                             $time, got);
                errors++;
                shown++;
                return;
            end
            want = renumbers_due.pop_front();
            ok = same("local_column", want.local_column, got.local_column);
            ok = same("owner_id", want.owner_id, got.owner_id) && ok;
            ok = same("is_ghost", want.is_ghost, got.is_ghost) && ok;
            ok = same("new_ghost", want.new_ghost, got.new_ghost) && ok;
            ok = same("list_position", want.list_position, got.list_position) && ok;
            ok = same("out_of_range", want.out_of_range, got.out_of_range) && ok;
            if (!ok) begin
                errors++;
                shown++;
            end
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    scl_pkg::t_in               i_item = '0;
    logic                       o_result_strobe;
    scl_pkg::t_out              o_result;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [scl_pkg::CFG_IW-1:0] i_cfg_index = '0;
    logic [scl_pkg::IDX_W-1:0]  i_cfg_data = '0;

    ghost_numbering book;
    int             recent_cols [$];
    int             layouts = 0;
    int             quiet_cycles = 0;

    sparse_column_localizer_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_item          (i_item),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_strobe === 1'b1) book.match_result(o_result);
    end

    // no transaction of any kind for too long means the block is stuck
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_strobe || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic scl_pkg::t_in mk(logic kind, int col);
        scl_pkg::t_in it;
        it.kind = kind;
        it.global_column = scl_pkg::COL_W'(col);
        return it;
    endfunction

    function automatic scl_pkg::t_in pick_item();
        scl_pkg::t_in it;
        int           roll;
        int           width;
        int           col;
        roll = $urandom_range(0, 99);
        width = book.span();
        if (roll < 4) return mk(scl_pkg::KIND_RESTART, $urandom_range(0, 65535));
        if (roll < 12 || width == 0) begin
            col = $urandom_range(0, 65535);
        end else if (roll < 18) begin
            case ($urandom_range(0, 4))
                0: col = 0;
                1: col = 65535;
                2: col = width - 1;
                3: col = width;
                default: col = int'(book.first_row(int'(book.rank)));
            endcase
        end else if (roll < 45 && recent_cols.size() != 0) begin
            // revisit a column so known ghosts come back
            col = recent_cols[$urandom_range(0, recent_cols.size() - 1)];
        end else begin
            col = $urandom_range(0, width - 1);
        end
        col = col & 16'hFFFF;
        recent_cols.push_back(col);
        if (recent_cols.size() > 48) void'(recent_cols.pop_front());
        return mk(scl_pkg::KIND_LOCALIZE, col);
    endfunction

    task automatic push_item(scl_pkg::t_in it);
        start <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        book.take_item(it);
    endtask

    task automatic write_layout(int rank, int np, int base, int extra);
        logic [scl_pkg::CFG_IW-1:0] idx;
        logic [scl_pkg::IDX_W-1:0]  val;
        int                         k0;
        k0 = $urandom_range(0, 3);
        while (book.renumbers_due.size() != 0 || busy) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        for (int k = 0; k < 4; k++) begin
            idx = REG_ORDER[(k + k0) % 4];
            case (idx)
                scl_pkg::REG_MY_RANK:   val = scl_pkg::IDX_W'(rank);
                scl_pkg::REG_NUM_PROCS: val = scl_pkg::IDX_W'(np);
                scl_pkg::REG_BASE_ROWS: val = scl_pkg::IDX_W'(base);
                default:                val = scl_pkg::IDX_W'(extra);
            endcase
            i_cfg_index <= idx;
            i_cfg_data <= val;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            book.set_reg(idx, val);
        end
        i_cfg_valid <= 1'b0;
        recent_cols.delete();
        layouts++;
    endtask

    // bursts of back-to-back transactions separated by random gaps
    task automatic run_phase(int count);
        int burst;
        burst = 0;
        for (int n = 0; n < count; n++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 30);
                if (n != 0 && $urandom_range(0, 3) != 0) begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 25)) @(posedge i_clk);
                end
            end
            push_item(pick_item());
            burst--;
        end
        start <= 1'b0;
    endtask

    initial begin
        int np;
        int eff;
        int rank;
        int base;
        int roll;
        book = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset layout holds no rows at all
        push_item(mk(scl_pkg::KIND_LOCALIZE, 0));
        push_item(mk(scl_pkg::KIND_LOCALIZE, 65535));
        push_item(mk(scl_pkg::KIND_RESTART, 65535));
        start <= 1'b0;

        // four blocks of 11, 11, 11 and 10 rows, localizing for rank 2
        write_layout(2, 4, 10, 3);
        push_item(mk(scl_pkg::KIND_LOCALIZE, 22));
        push_item(mk(scl_pkg::KIND_LOCALIZE, 32));
        push_item(mk(scl_pkg::KIND_LOCALIZE, 0));
        push_item(mk(scl_pkg::KIND_LOCALIZE, 10));
        push_item(mk(scl_pkg::KIND_LOCALIZE, 0));
        push_item(mk(scl_pkg::KIND_LOCALIZE, 42));
        push_item(mk(scl_pkg::KIND_LOCALIZE, 43));
        push_item(mk(scl_pkg::KIND_LOCALIZE, 65535));
        push_item(mk(scl_pkg::KIND_LOCALIZE, 11));
        push_item(mk(scl_pkg::KIND_LOCALIZE, 21));
        push_item(mk(scl_pkg::KIND_RESTART, 0));
        push_item(mk(scl_pkg::KIND_LOCALIZE, 0));
        push_item(mk(scl_pkg::KIND_LOCALIZE, 22));
        push_item(mk(scl_pkg::KIND_LOCALIZE, 33));
        start <= 1'b0;

        foreach (FIXED_LAYOUTS[i]) begin
            write_layout(FIXED_LAYOUTS[i][0], FIXED_LAYOUTS[i][1],
                         FIXED_LAYOUTS[i][2], FIXED_LAYOUTS[i][3]);
            run_phase(PHASE_ITEMS);
        end

        for (int i = 0; i < 8; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 60) np = $urandom_range(1, 64);
            else if (roll < 75) np = $urandom_range(65, 127);
            else if (roll < 80) np = 0;
            else np = 1;
            eff = (np == 0) ? 1 : ((np > scl_pkg::MAX_PROCS) ? scl_pkg::MAX_PROCS : np);
            rank = ($urandom_range(0, 4) != 0) ? $urandom_range(0, eff - 1)
                                                : $urandom_range(0, 63);
            roll = $urandom_range(0, 99);
            if (roll < 50) base = $urandom_range(0, 200);
            else if (roll < 80) base = $urandom_range(0, 2000);
            else if (roll < 95) base = $urandom_range(0, 65536);
            else base = $urandom_range(65537, 131071);
            write_layout(rank, np, base, $urandom_range(0, 63));
            run_phase(PHASE_ITEMS);
        end

        while (book.renumbers_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        book.errors += book.renumbers_due.size();

        $display("covered %0d layouts: %0d local, %0d new ghost, %0d repeat ghost columns",
                 layouts, book.n_local, book.n_new, book.n_seen);
        $display("plus %0d out-of-range columns and %0d restarts, %0d bad results",
                 book.n_oor, book.n_restart, book.errors);
        if (book.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/core/scl_pkg.sv
rtl/core/scl_owner_search.sv
rtl/core/scl_rx_count.sv
rtl/core/sparse_column_localizer_unit.sv
sim/tb.sv
